// ===== hw/rtl/led_blink_breathe_generator_assert.svh =====
// assertion macros shared by the led pattern generator rtl
// no dependencies
`ifndef LED_BLINK_BREATHE_GENERATOR_ASSERT_SVH
`define LED_BLINK_BREATHE_GENERATOR_ASSERT_SVH

// same-cycle implication
`define LBB_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LBB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/lbb_pkg.sv =====
// types, codes and constants of the led blink / breathe generator
// no dependencies
package lbb_pkg;

    localparam int DEFAULT_CHANNELS = 5;
    localparam int DIV_W            = 32;

    localparam logic [2:0] MODE_OFF     = 3'd0;
    localparam logic [2:0] MODE_ON      = 3'd1;
    localparam logic [2:0] MODE_PWM     = 3'd2;
    localparam logic [2:0] MODE_BLINK   = 3'd3;
    localparam logic [2:0] MODE_BREATHE = 3'd4;

    localparam logic [7:0]  RST_CEILING = 8'd255;
    localparam logic [15:0] RST_PERIOD  = 16'd1000;
    localparam logic [9:0]  RST_DUTY    = 10'd500;

    localparam logic [9:0]  DUTY_FULL   = 10'd1000;
    localparam logic [9:0]  RISE_MAX    = 10'd999;
    localparam logic [15:0] BREATHE_MIN = 16'd2;
    localparam logic [7:0]  LEVEL_MAX   = 8'd255;

    // x / 1000 as (x * ceil(2^36 / 1000)) >> 36, exact for x below 2^26
    localparam logic [26:0] RECIP_PERMILLE = 27'd68719477;
    localparam int          RECIP_SHIFT    = 36;
    // x / 255 as ((x + 1) * 257) >> 16, exact for x up to 255 * 255
    localparam logic [8:0]  RECIP_LEVEL    = 9'd257;
    localparam int          LEVEL_SHIFT    = 16;

    localparam logic DSEL_PHASE = 1'b0;
    localparam logic DSEL_RAMP  = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [2:0]  channel;
        logic [2:0]  led_mode;
        logic [7:0]  level_ceiling;
        logic [15:0] period_ms;
        logic [15:0] duty_permille;
        logic [31:0] now_ms;
    } in_t;

    typedef struct packed {
        logic [2:0] out_channel;
        logic [7:0] drive_level;
        logic       is_lit;
        logic       last_of_run;
    } out_t;

    typedef struct packed {
        logic       capture_set;
        logic       capture_tick;
        logic       load;
        logic       div_start;
        logic       div_sel;
        logic       mul_a;
        logic       cap_a;
        logic       cap_b;
        logic       mul_c;
        logic       cap_c;
        logic       mul_d;
        logic       cap_d;
        logic       emit;
        logic       next_chan;
    } cmd_t;

    typedef struct packed {
        logic       in_set;
        logic       in_oob;
        logic [2:0] mode;
        logic       div_done;
        logic       out_free;
        logic       is_last;
    } status_t;

endpackage

// ===== hw/rtl/lbb_divider.sv =====
// shared restoring divider, one quotient bit per cycle
// depends on lbb_pkg and the assertion header
`include "led_blink_breathe_generator_assert.svh"

module lbb_divider (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [lbb_pkg::DIV_W-1:0]  dividend,
    input  logic [lbb_pkg::DIV_W-1:0]  divisor,
    output logic [lbb_pkg::DIV_W-1:0]  quotient,
    output logic [lbb_pkg::DIV_W-1:0]  remainder,
    output logic                       busy,
    output logic                       done
);
    localparam int W   = lbb_pkg::DIV_W;
    localparam int CNT = $clog2(W);

    logic [W-1:0]   rem_reg, rem_next;
    logic [W-1:0]   quo_reg, quo_next;
    logic [W-1:0]   dvs_reg;
    logic [CNT-1:0] cnt_reg;
    logic           busy_reg, done_reg;
    logic [W:0]     trial, diff;

    always_comb begin
        trial = {rem_reg, quo_reg[W-1]};
        diff  = trial - {1'b0, dvs_reg};
        if (!diff[W]) begin
            rem_next = diff[W-1:0];
            quo_next = {quo_reg[W-2:0], 1'b1};
        end else begin
            rem_next = trial[W-1:0];
            quo_next = {quo_reg[W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT'(W - 1);
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign busy      = busy_reg;
    assign done      = done_reg;

    `LBB_ASSERT_NOW(a_no_restart, aclk, aresetn, start, !busy_reg, "divider restarted while busy")

endmodule

// ===== hw/rtl/lbb_datapath.sv =====
// channel table, operand registers, shared divider and output register
// depends on lbb_pkg and lbb_divider
module lbb_datapath #(
    parameter int LED_CHANNELS = lbb_pkg::DEFAULT_CHANNELS
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  lbb_pkg::in_t     s_data,
    output lbb_pkg::out_t    m_data,
    output logic             m_valid,
    input  logic             m_ready,
    input  lbb_pkg::cmd_t    cmd,
    output lbb_pkg::status_t status
);
    localparam int CH_W = (LED_CHANNELS > 1) ? $clog2(LED_CHANNELS) : 1;
    localparam int W    = lbb_pkg::DIV_W;

    logic [2:0]  mode_tab   [LED_CHANNELS];
    logic [7:0]  ceil_tab   [LED_CHANNELS];
    logic [15:0] period_tab [LED_CHANNELS];
    logic [9:0]  duty_tab   [LED_CHANNELS];
    logic [31:0] phase_tab  [LED_CHANNELS];

    logic [CH_W-1:0] idx_reg;
    logic            single_reg;
    logic [31:0]     now_reg;
    logic [2:0]      mode_reg;
    logic [7:0]      ceil_reg;
    logic [15:0]     p_reg;
    logic [9:0]      duty_reg;
    logic [31:0]     el_reg;
    logic [31:0]     prod_reg;
    logic [15:0]     ont_reg;
    logic [15:0]     t_reg;
    logic            up_reg;
    logic [15:0]     den_reg;
    logic [7:0]      ramp_reg;
    logic [7:0]      lvl_reg;
    logic            lit_reg;
    lbb_pkg::out_t   out_reg;
    logic            m_valid_reg;

    logic [CH_W-1:0] set_idx;
    logic [9:0]      duty_clamped;
    logic [2:0]      cur_mode;
    logic [7:0]      cur_ceil;
    logic [15:0]     cur_per;
    logic [9:0]      cur_duty;
    logic [15:0]     p_eff;
    logic [9:0]      d_eff;
    logic [15:0]     r16;
    logic [52:0]     ont_prod;
    logic [25:0]     lvl_prod;
    logic [W-1:0]    dvd, dvs, quo, rem;
    logic            div_busy, div_done;
    logic [4:0]      idx5;

    assign set_idx      = CH_W'(5'(s_data.channel));
    assign duty_clamped = (s_data.duty_permille > 16'(lbb_pkg::DUTY_FULL))
                        ? lbb_pkg::DUTY_FULL : s_data.duty_permille[9:0];
    assign cur_mode = mode_tab[idx_reg];
    assign cur_ceil = ceil_tab[idx_reg];
    assign cur_per  = period_tab[idx_reg];
    assign cur_duty = duty_tab[idx_reg];
    assign r16      = rem[15:0];
    assign idx5     = 5'(idx_reg);

    // constant divisions by reciprocal multiplication
    assign ont_prod = 53'(prod_reg[25:0]) * 53'(lbb_pkg::RECIP_PERMILLE);
    assign lvl_prod = 26'(17'(prod_reg[15:0]) + 17'd1) * 26'(lbb_pkg::RECIP_LEVEL);

    // period and duty as the mode sees them
    always_comb begin
        if (cur_mode == lbb_pkg::MODE_BREATHE) begin
            p_eff = (cur_per < lbb_pkg::BREATHE_MIN) ? lbb_pkg::BREATHE_MIN : cur_per;
            if (cur_duty == '0) begin
                d_eff = 10'd1;
            end else if (cur_duty >= lbb_pkg::DUTY_FULL) begin
                d_eff = lbb_pkg::RISE_MAX;
            end else begin
                d_eff = cur_duty;
            end
        end else begin
            p_eff = (cur_per == '0) ? 16'd1 : cur_per;
            d_eff = cur_duty;
        end
    end

    always_comb begin
        case (cmd.div_sel)
            lbb_pkg::DSEL_PHASE: begin
                dvd = el_reg;
                dvs = W'(p_reg);
            end
            lbb_pkg::DSEL_RAMP: begin
                dvd = prod_reg;
                dvs = W'(den_reg);
            end
            default: begin
                dvd = el_reg;
                dvs = W'(p_reg);
            end
        endcase
    end

    lbb_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (dvd),
        .divisor   (dvs),
        .quotient  (quo),
        .remainder (rem),
        .busy      (div_busy),
        .done      (div_done)
    );

    // channel table
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LED_CHANNELS; i++) begin
                mode_tab[i]   <= lbb_pkg::MODE_OFF;
                ceil_tab[i]   <= lbb_pkg::RST_CEILING;
                period_tab[i] <= lbb_pkg::RST_PERIOD;
                duty_tab[i]   <= lbb_pkg::RST_DUTY;
                phase_tab[i]  <= '0;
            end
        end else if (cmd.capture_set) begin
            mode_tab[set_idx]   <= s_data.led_mode;
            ceil_tab[set_idx]   <= s_data.level_ceiling;
            period_tab[set_idx] <= s_data.period_ms;
            duty_tab[set_idx]   <= duty_clamped;
            phase_tab[set_idx]  <= s_data.now_ms;
        end else if (cmd.cap_b) begin
            // phase start moves by whole periods: now minus the remainder
            phase_tab[idx_reg] <= now_reg - 32'(r16);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg    <= '0;
            single_reg <= 1'b0;
        end else if (cmd.capture_set) begin
            idx_reg    <= set_idx;
            single_reg <= 1'b1;
        end else if (cmd.capture_tick) begin
            idx_reg    <= '0;
            single_reg <= 1'b0;
        end else if (cmd.next_chan) begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture_set || cmd.capture_tick) begin
            now_reg <= s_data.now_ms;
        end
        if (cmd.load) begin
            mode_reg <= cur_mode;
            ceil_reg <= cur_ceil;
            p_reg    <= p_eff;
            duty_reg <= cur_duty;
            el_reg   <= now_reg - phase_tab[idx_reg];
            if (cur_mode == lbb_pkg::MODE_ON || cur_mode == lbb_pkg::MODE_PWM) begin
                lvl_reg <= cur_ceil;
                lit_reg <= (cur_ceil != '0);
            end else begin
                lvl_reg <= '0;
                lit_reg <= 1'b0;
            end
        end
        if (cmd.mul_a) begin
            ont_reg <= ont_prod[lbb_pkg::RECIP_SHIFT +: 16];
        end
        if (cmd.cap_a) begin
            if (mode_reg == lbb_pkg::MODE_BREATHE) begin
                if (ont_reg == '0) begin
                    t_reg <= 16'd1;
                end else if (ont_reg >= p_reg) begin
                    t_reg <= p_reg - 16'd1;
                end else begin
                    t_reg <= ont_reg;
                end
            end else begin
                t_reg <= ont_reg;
            end
        end
        if (cmd.cap_b) begin
            el_reg <= 32'(r16);
            if (mode_reg == lbb_pkg::MODE_BLINK) begin
                if (duty_reg >= lbb_pkg::DUTY_FULL) begin
                    lit_reg <= 1'b1;
                    lvl_reg <= ceil_reg;
                end else if (duty_reg == '0 || r16 >= t_reg) begin
                    lit_reg <= 1'b0;
                    lvl_reg <= '0;
                end else begin
                    lit_reg <= 1'b1;
                    lvl_reg <= ceil_reg;
                end
            end
        end
        if (cmd.mul_c) begin
            up_reg   <= (el_reg[15:0] < t_reg);
            den_reg  <= (el_reg[15:0] < t_reg) ? t_reg : (p_reg - t_reg);
        end
        if (cmd.cap_c) begin
            ramp_reg <= up_reg ? quo[7:0] : (lbb_pkg::LEVEL_MAX - quo[7:0]);
        end
        if (cmd.cap_d) begin
            lvl_reg <= lvl_prod[lbb_pkg::LEVEL_SHIFT +: 8];
            lit_reg <= (lvl_prod[lbb_pkg::LEVEL_SHIFT +: 8] != '0);
        end
        // prod_reg is shared by the multiply steps
        if (cmd.load) begin
            prod_reg <= 32'(p_eff * d_eff);
        end else if (cmd.mul_c) begin
            prod_reg <= 32'((el_reg[15:0] < t_reg ? el_reg[15:0] : el_reg[15:0] - t_reg)
                            * lbb_pkg::LEVEL_MAX);
        end else if (cmd.mul_d) begin
            prod_reg <= 32'(ramp_reg * ceil_reg);
        end
        if (cmd.emit) begin
            out_reg.out_channel <= idx5[2:0];
            out_reg.drive_level <= lvl_reg;
            out_reg.is_lit      <= lit_reg;
            out_reg.last_of_run <= status.is_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_data  = out_reg;
    assign m_valid = m_valid_reg;

    always_comb begin
        status.in_set   = s_data.req_type;
        status.in_oob   = (5'(s_data.channel) >= 5'(LED_CHANNELS));
        status.mode     = cur_mode;
        status.div_done = div_done && !div_busy;
        status.out_free = !m_valid_reg || m_ready;
        status.is_last  = single_reg || (idx_reg == CH_W'(LED_CHANNELS - 1));
    end

endmodule

// ===== hw/rtl/lbb_controller.sv =====
// sequencer that walks channels and steps the datapath through each mode
// depends on lbb_pkg
module lbb_controller (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  lbb_pkg::status_t status,
    output lbb_pkg::cmd_t    cmd
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOAD  = 4'd1;
    localparam logic [3:0] S_MULA  = 4'd2;
    localparam logic [3:0] S_CAPA  = 4'd3;
    localparam logic [3:0] S_DIVB  = 4'd4;
    localparam logic [3:0] S_WB    = 4'd5;
    localparam logic [3:0] S_MULC  = 4'd6;
    localparam logic [3:0] S_DIVC  = 4'd7;
    localparam logic [3:0] S_WC    = 4'd8;
    localparam logic [3:0] S_MULD  = 4'd9;
    localparam logic [3:0] S_SCALE = 4'd10;
    localparam logic [3:0] S_EMIT  = 4'd11;

    logic [3:0] state_reg, state_next;

    always_comb begin
        cmd        = '0;
        s_ready    = 1'b0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (!status.in_set) begin
                        cmd.capture_tick = 1'b1;
                        state_next       = S_LOAD;
                    end else if (!status.in_oob) begin
                        cmd.capture_set = 1'b1;
                        state_next      = S_LOAD;
                    end
                end
            end
            S_LOAD: begin
                cmd.load = 1'b1;
                if (status.mode == lbb_pkg::MODE_BLINK ||
                    status.mode == lbb_pkg::MODE_BREATHE) begin
                    state_next = S_MULA;
                end else begin
                    state_next = S_EMIT;
                end
            end
            S_MULA: begin
                cmd.mul_a  = 1'b1;
                state_next = S_CAPA;
            end
            S_CAPA: begin
                cmd.cap_a  = 1'b1;
                state_next = S_DIVB;
            end
            S_DIVB: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = lbb_pkg::DSEL_PHASE;
                state_next    = S_WB;
            end
            S_WB: begin
                cmd.div_sel = lbb_pkg::DSEL_PHASE;
                if (status.div_done) begin
                    cmd.cap_b  = 1'b1;
                    state_next = (status.mode == lbb_pkg::MODE_BREATHE) ? S_MULC : S_EMIT;
                end
            end
            S_MULC: begin
                cmd.mul_c  = 1'b1;
                state_next = S_DIVC;
            end
            S_DIVC: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = lbb_pkg::DSEL_RAMP;
                state_next    = S_WC;
            end
            S_WC: begin
                cmd.div_sel = lbb_pkg::DSEL_RAMP;
                if (status.div_done) begin
                    cmd.cap_c  = 1'b1;
                    state_next = S_MULD;
                end
            end
            S_MULD: begin
                cmd.mul_d  = 1'b1;
                state_next = S_SCALE;
            end
            S_SCALE: begin
                cmd.cap_d  = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.is_last) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.next_chan = 1'b1;
                        state_next    = S_LOAD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/led_blink_breathe_generator.sv =====
// led blink / breathe generator: one word per channel on a tick, one on a set to a
// valid channel; per channel, off/on/pwm skip the divider, blink uses the shared
// divider once and breathe twice, each division a start, 32 steps and done
// a tick walks all channels in turn and waits on output stalls; one input item at a time
// synchronous active-low reset restores every channel to off, ceiling 255, 1000 ms, 500
`include "led_blink_breathe_generator_assert.svh"

module led_blink_breathe_generator #(
    parameter int LED_CHANNELS = lbb_pkg::DEFAULT_CHANNELS
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  lbb_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output lbb_pkg::out_t m_data
);
    lbb_pkg::cmd_t    cmd;
    lbb_pkg::status_t status;

    lbb_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    lbb_datapath #(
        .LED_CHANNELS (LED_CHANNELS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_data  (m_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    `LBB_ASSERT_NEXT(a_tick_busy, aclk, aresetn, s_valid && s_ready && !s_data.req_type, !s_ready, "tick: still ready")
    `LBB_ASSERT_NOW(a_run_busy, aclk, aresetn, m_valid && m_ready && !m_data.last_of_run, !s_ready, "ready mid run")

endmodule

// ===== tb/led_blink_breathe_generator_test.sv =====
// self-checking testbench of the led blink / breathe generator
// depends on lbb_pkg and the led_blink_breathe_generator rtl
`timescale 1ns / 1ps

module led_blink_breathe_generator_test;

    localparam int NCH       = 5;
    localparam int CYC_LIMIT = 1500000;

    typedef enum logic {REQ_TICK = 1'b0, REQ_SET = 1'b1} req_e;

    typedef struct {
        lbb_pkg::in_t  w;
        bit            typed;
        lbb_pkg::out_t exp;
    } row_t;

    logic          aclk;
    logic          aresetn;
    logic          s_valid;
    logic          s_ready;
    lbb_pkg::in_t  s_data;
    logic          m_valid;
    logic          m_ready;
    lbb_pkg::out_t m_data;

    led_blink_breathe_generator #(.LED_CHANNELS(NCH)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // predictor copy of the channel table
    logic [2:0]  p_mode    [NCH];
    logic [7:0]  p_ceiling [NCH];
    logic [15:0] p_period  [NCH];
    logic [9:0]  p_duty    [NCH];
    logic [31:0] p_start   [NCH];

    lbb_pkg::out_t level_q[$];
    int   mismatches;
    int   cycles;
    bit   long_stall_req;
    bit   long_stall_done;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT) begin
            $display("led_blink_breathe_generator test failed");
            $finish;
        end
    end

    function automatic logic [31:0] advance_phase(int c, logic [31:0] now, logic [31:0] per);
        logic [31:0] el;
        el = now - p_start[c];
        if (el >= per) begin
            p_start[c] = p_start[c] + (el / per) * per;
            el = now - p_start[c];
        end
        return el;
    endfunction

    function automatic lbb_pkg::out_t eval_level(int c, logic [31:0] now, bit last);
        lbb_pkg::out_t r;
        logic [31:0] per, el, ont, rise, rms, fms, ramp, lvl, ceil, duty;
        ceil = 32'(p_ceiling[c]);
        duty = 32'(p_duty[c]);
        r.out_channel = c[2:0];
        r.last_of_run = last;
        r.drive_level = 8'd0;
        r.is_lit = 1'b0;
        case (p_mode[c])
            lbb_pkg::MODE_ON, lbb_pkg::MODE_PWM: begin
                r.drive_level = ceil[7:0];
                r.is_lit = (ceil != 0);
            end
            lbb_pkg::MODE_BLINK: begin
                per = (p_period[c] == 0) ? 32'd1 : 32'(p_period[c]);
                el = advance_phase(c, now, per);
                if (duty > 1000) duty = 1000;
                ont = (per * duty) / 1000;
                r.is_lit = (duty >= 1000) ? 1'b1 : (duty == 0) ? 1'b0 : (el < ont);
                r.drive_level = r.is_lit ? ceil[7:0] : 8'd0;
            end
            lbb_pkg::MODE_BREATHE: begin
                per = (p_period[c] < 2) ? 32'd2 : 32'(p_period[c]);
                rise = duty;
                if (rise == 0) rise = 1;
                if (rise >= 1000) rise = 999;
                rms = (per * rise) / 1000;
                if (rms == 0) rms = 1;
                if (rms >= per) rms = per - 1;
                fms = per - rms;
                el = advance_phase(c, now, per);
                if (el < rms) ramp = (el * 255) / rms;
                else ramp = 255 - (((el - rms) * 255) / fms);
                lvl = ((ramp & 32'hFF) * ceil) / 255;
                r.drive_level = lvl[7:0];
                r.is_lit = (lvl != 0);
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic predict_levels(lbb_pkg::in_t it);
        int ch;
        if (it.req_type == REQ_SET) begin
            ch = int'(it.channel);
            if (ch >= NCH) return;
            p_mode[ch] = it.led_mode;
            p_ceiling[ch] = it.level_ceiling;
            p_period[ch] = it.period_ms;
            p_duty[ch] = (it.duty_permille > 1000) ? 10'd1000 : it.duty_permille[9:0];
            p_start[ch] = it.now_ms;
            level_q.push_back(eval_level(ch, it.now_ms, 1'b1));
        end else begin
            for (int c = 0; c < NCH; c++)
                level_q.push_back(eval_level(c, it.now_ms, c == NCH - 1));
        end
    endtask

    // receiver: own stall pattern plus one long hold-off on request
    initial begin
        int hold;
        m_ready = 1'b0;
        long_stall_done = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            @(posedge aclk);
            if (long_stall_req && !long_stall_done) begin
                m_ready <= 1'b0;
                hold = 0;
                while (hold < 3000) begin
                    @(posedge aclk);
                    hold++;
                end
                long_stall_done = 1'b1;
            end else if ((cycles / 300) % 4 == 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    always @(posedge aclk) begin
        lbb_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (level_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: ch %0d lvl %0d lit %0d last %0d",
                             m_data.out_channel, m_data.drive_level,
                             m_data.is_lit, m_data.last_of_run);
            end else begin
                want = level_q.pop_front();
                if (m_data !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 want.out_channel, want.drive_level, want.is_lit,
                                 want.last_of_run, m_data.out_channel,
                                 m_data.drive_level, m_data.is_lit, m_data.last_of_run);
                end
            end
        end
    end

    task automatic send_word(lbb_pkg::in_t it);
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_levels(it);
    endtask

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 2) == 0) ? int'($urandom_range(1, 40)) : 0;
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    function automatic lbb_pkg::in_t mk(req_e rq, int ch, int md, int ceil, int per, int duty,
                                        logic [31:0] now);
        lbb_pkg::in_t it;
        it.req_type = rq;
        it.channel = ch[2:0];
        it.led_mode = md[2:0];
        it.level_ceiling = ceil[7:0];
        it.period_ms = per[15:0];
        it.duty_permille = duty[15:0];
        it.now_ms = now;
        return it;
    endfunction

    function automatic lbb_pkg::out_t mk_out(int ch, int lvl, bit lit, bit last);
        lbb_pkg::out_t r;
        r.out_channel = ch[2:0];
        r.drive_level = lvl[7:0];
        r.is_lit = lit;
        r.last_of_run = last;
        return r;
    endfunction

    function automatic row_t plain(lbb_pkg::in_t w);
        row_t r;
        r.w = w;
        r.typed = 1'b0;
        r.exp = '0;
        return r;
    endfunction

    // the typed value is the first result of the row
    function automatic row_t known(lbb_pkg::in_t w, lbb_pkg::out_t exp);
        row_t r;
        r.w = w;
        r.typed = 1'b1;
        r.exp = exp;
        return r;
    endfunction

    function automatic lbb_pkg::in_t rand_word(logic [31:0] base);
        lbb_pkg::in_t it;
        logic [95:0] raw;
        it = '0;
        if ($urandom_range(0, 9) == 0) begin
            raw = {$urandom, $urandom, $urandom};
            it = raw[$bits(lbb_pkg::in_t)-1:0];
        end else begin
            it.req_type = 1'($urandom_range(0, 1));
            it.channel = 3'($urandom_range(0, NCH - 1));
            it.led_mode = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                      : 3'($urandom_range(0, 4));
            it.level_ceiling = 8'($urandom);
            it.period_ms = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(0, 3000));
            it.duty_permille = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                           : 16'($urandom_range(0, 1000));
            it.now_ms = base + $urandom_range(0, 5000);
        end
        return it;
    endfunction

    row_t stim_tab[$];

    initial begin
        logic [31:0] t;
        lbb_pkg::in_t w;
        int idx;
        mismatches = 0;
        cycles = 0;
        long_stall_req = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        aresetn = 1'b0;
        for (int c = 0; c < NCH; c++) begin
            p_mode[c] = lbb_pkg::MODE_OFF;
            p_ceiling[c] = lbb_pkg::RST_CEILING;
            p_period[c] = lbb_pkg::RST_PERIOD;
            p_duty[c] = lbb_pkg::RST_DUTY;
            p_start[c] = 0;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table: reset tick, every mode, extremes and edge cases
        stim_tab.push_back(known(mk(REQ_TICK, 0, 0, 0, 0, 0, 32'd0),
                                 mk_out(0, 0, 1'b0, 1'b0)));
        stim_tab.push_back(known(mk(REQ_SET, 0, lbb_pkg::MODE_ON, 255, 0, 0, 32'd5),
                                 mk_out(0, 255, 1'b1, 1'b1)));
        stim_tab.push_back(known(mk(REQ_SET, 1, lbb_pkg::MODE_PWM, 0, 0, 0, 32'd5),
                                 mk_out(1, 0, 1'b0, 1'b1)));
        stim_tab.push_back(plain(mk(REQ_SET, 2, lbb_pkg::MODE_BLINK, 200, 0, 500, 32'd10)));
        // full duty blink stays lit even with a dark ceiling
        stim_tab.push_back(known(mk(REQ_SET, 3, lbb_pkg::MODE_BLINK, 0, 100, 1000, 32'd10),
                                 mk_out(3, 0, 1'b1, 1'b1)));
        stim_tab.push_back(known(mk(REQ_SET, 4, lbb_pkg::MODE_BLINK, 255, 100, 0, 32'd10),
                                 mk_out(4, 0, 1'b0, 1'b1)));
        stim_tab.push_back(plain(mk(REQ_TICK, 7, 7, 255, 65535, 65535, 32'd77)));
        stim_tab.push_back(plain(mk(REQ_SET, 2, lbb_pkg::MODE_BREATHE, 255, 0, 0, 32'd100)));
        stim_tab.push_back(plain(mk(REQ_SET, 3, lbb_pkg::MODE_BREATHE, 255, 1, 65535,
                                    32'd100)));
        stim_tab.push_back(plain(mk(REQ_SET, 4, lbb_pkg::MODE_BREATHE, 128, 65535, 500,
                                    32'hFFFF_FF00)));
        stim_tab.push_back(plain(mk(REQ_TICK, 0, 0, 0, 0, 0, 32'h0000_0100)));
        stim_tab.push_back(known(mk(REQ_SET, 0, 5, 255, 100, 100, 32'd0),
                                 mk_out(0, 0, 1'b0, 1'b1)));
        stim_tab.push_back(plain(mk(REQ_SET, 1, 7, 255, 100, 100, 32'd0)));
        stim_tab.push_back(plain(mk(REQ_SET, 5, lbb_pkg::MODE_ON, 255, 100, 100, 32'd0)));
        stim_tab.push_back(plain(mk(REQ_SET, 7, lbb_pkg::MODE_ON, 255, 100, 100, 32'd0)));
        stim_tab.push_back(plain(mk(REQ_SET, 2, lbb_pkg::MODE_BLINK, 255, 1000, 1001, 32'd3)));
        stim_tab.push_back(plain(mk(REQ_TICK, 0, 0, 0, 0, 0, 32'hFFFF_FFFF)));
        stim_tab.push_back(plain(mk(REQ_SET, 0, lbb_pkg::MODE_OFF, 255, 1000, 500, 32'd9)));
        stim_tab.push_back(plain(mk(REQ_TICK, 0, 0, 0, 0, 0, 32'hABCD_0123)));
        foreach (stim_tab[i]) begin
            send_word(stim_tab[i].w);
            if (stim_tab[i].typed) begin
                idx = level_q.size() - ((stim_tab[i].w.req_type == REQ_SET) ? 1 : NCH);
                level_q[idx] = stim_tab[i].exp;
            end
            idle_gap();
        end
        s_valid <= 1'b0;

        // wait for all results, sender paused
        while (level_q.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);

        t = $urandom;
        for (int i = 0; i < 80; i++) begin
            if (i == 25) long_stall_req = 1'b1;
            if (i == 55) begin
                s_valid <= 1'b0;
                while (level_q.size() != 0) @(posedge aclk);
            end
            w = rand_word(t);
            t = w.now_ms;
            send_word(w);
            idle_gap();
        end
        s_valid <= 1'b0;

        while (level_q.size() != 0) @(posedge aclk);
        repeat (1000) @(posedge aclk);
        if (mismatches == 0 && level_q.size() == 0)
            $display("led_blink_breathe_generator test passed");
        else
            $display("led_blink_breathe_generator test failed");
        $finish;
    end
endmodule
